[sv/isn_pkg.sv]
// ----------------------------------------------------------------------------
// isn_pkg - shared types and constants for the image header size sniffer
// Format codes, signature bytes and the result record.
// ----------------------------------------------------------------------------
package isn_pkg;

	typedef enum logic [1:0] {
		FMT_UNKNOWN = 2'd0,
		FMT_BMP     = 2'd1,
		FMT_PNG     = 2'd2,
		FMT_JPEG    = 2'd3
	} img_fmt_t;

	localparam logic [7:0] BMP_SIG0  = 8'h42;	// 'B'
	localparam logic [7:0] BMP_SIG1  = 8'h4D;	// 'M'
	localparam logic [7:0] JPEG_SIG0 = 8'hFF;
	localparam logic [7:0] JPEG_SIG1 = 8'hD8;
	localparam logic [23:0] PNG_SIG_LO = 24'h4E5089;	// 0x89 'P' 'N', byte 0 lowest
	localparam logic [7:0] PNG_SIG3  = 8'h47;	// 'G'
	localparam logic [7:0] JPEG_MARK = 8'hFF;
	localparam logic [7:0] SOF_LO    = 8'hC0;
	localparam logic [7:0] SOF_HI    = 8'hC3;

	localparam int BMP_W_FIRST = 18;
	localparam int BMP_W_LAST  = 21;
	localparam int BMP_H_FIRST = 22;
	localparam int BMP_H_LAST  = 25;
	localparam int PNG_W_FIRST = 16;
	localparam int PNG_W_LAST  = 19;
	localparam int PNG_H_FIRST = 20;
	localparam int PNG_H_LAST  = 23;

	localparam logic [3:0] SOF_CNT_MAX = 4'd9;
	localparam logic [3:0] SOF_H_HI    = 4'd5;
	localparam logic [3:0] SOF_H_LO    = 4'd6;
	localparam logic [3:0] SOF_W_HI    = 4'd7;
	localparam logic [3:0] SOF_W_LO    = 4'd8;

	typedef struct packed {
		img_fmt_t           fmt;
		logic signed [31:0] width;
		logic signed [31:0] height;
		logic [31:0]        size;
	} img_result_t;

endpackage

[sv/image_header_size_sniffer.sv]
// ----------------------------------------------------------------------------
// image_header_size_sniffer - BMP / PNG / JPEG header size sniffer
// Streams an image file byte by byte and reports its format and dimensions.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one file byte per request on s_axis_tdata, with
//   s_axis_tlast high on the final byte of the file. No result is produced
//   for the other bytes.
//   On the final byte one result request appears on the master side: format
//   on m_axis_tuser, width, height and byte count on m_axis_tdata.
//   Throughput: one byte per cycle while s_axis_tready is high; parsing is a
//   single pass of compares and byte-lane inserts on the state registers.
//   Results are registered: output register first, skid slot if it is busy.
//   A stalled receiver is absorbed by the output register plus a one-entry
//   skid slot; s_axis_tready drops only when both hold results.
//   After a final byte the parser returns to its reset state, so the next
//   file may start with the next byte taken.
//   Reset (arst_n low) clears the parser state and drops any pending results.
// ----------------------------------------------------------------------------
module image_header_size_sniffer import isn_pkg::*; #(
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,	// [7:0] data_byte
	input  logic        s_axis_tlast,	// last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,	// [31:0] image_width, [63:32] image_height,
						// [95:64] total_bytes
	output logic [1:0]  m_axis_tuser	// [1:0] image_format
);

	logic        take;
	logic        res_push;
	logic        buf_full;
	img_result_t res;
	img_result_t out_res;

	assign s_axis_tready = !buf_full;
	assign take          = s_axis_tvalid && !buf_full;

	isn_parse #(
		.COUNT_BITS(COUNT_BITS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (s_axis_tdata),
		.last_byte (s_axis_tlast),
		.res_push  (res_push),
		.res       (res)
	);

	isn_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res),
		.full      (buf_full),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_res)
	);

	assign m_axis_tdata = {out_res.size, out_res.height, out_res.width};
	assign m_axis_tuser = out_res.fmt;

endmodule

[sv/isn_parse.sv]
// ----------------------------------------------------------------------------
// isn_parse - per-byte header parser
// Holds the running file state, decodes the signature and captures the size
// fields; on the final byte emits a result and returns to the reset state.
// ----------------------------------------------------------------------------
module isn_parse import isn_pkg::*; #(
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        res_push,
	output img_result_t res
);

	logic [COUNT_BITS-1:0] cnt_q, cnt_nxt;
	logic [23:0] magic_q, magic_nxt;
	img_fmt_t    fmt_q, fmt_nxt;
	logic [7:0]  prev_q;
	logic        mark_q, mark_nxt;
	logic [3:0]  after_q, after_nxt;
	logic [31:0] wid_q, wid_nxt;
	logic [31:0] hgt_q, hgt_nxt;
	logic [31:0] size_sat;

	function automatic logic in_rng(logic [COUNT_BITS-1:0] v, int lo, int hi);
		in_rng = (v >= COUNT_BITS'(lo)) && (v <= COUNT_BITS'(hi));
	endfunction

	always_comb begin
		magic_nxt = magic_q;
		fmt_nxt   = fmt_q;
		mark_nxt  = mark_q;
		after_nxt = after_q;
		wid_nxt   = wid_q;
		hgt_nxt   = hgt_q;

		if (cnt_q < COUNT_BITS'(3))
			magic_nxt = magic_q | (24'(data_byte) << {cnt_q[1:0], 3'b000});

		if (cnt_q == COUNT_BITS'(1)) begin
			if (magic_q[7:0] == BMP_SIG0 && data_byte == BMP_SIG1)
				fmt_nxt = FMT_BMP;
			else if (magic_q[7:0] == JPEG_SIG0 && data_byte == JPEG_SIG1)
				fmt_nxt = FMT_JPEG;
		end else if (cnt_q == COUNT_BITS'(3)) begin
			if (magic_q == PNG_SIG_LO && data_byte == PNG_SIG3)
				fmt_nxt = FMT_PNG;
		end

		unique case (fmt_nxt)
			FMT_BMP: begin
				// little-endian: lane = idx - first, first is 2 mod 4
				if (in_rng(cnt_q, BMP_W_FIRST, BMP_W_LAST))
					wid_nxt = wid_q | (32'(data_byte) << {cnt_q[1:0] - 2'd2, 3'b000});
				else if (in_rng(cnt_q, BMP_H_FIRST, BMP_H_LAST))
					hgt_nxt = hgt_q | (32'(data_byte) << {cnt_q[1:0] - 2'd2, 3'b000});
			end
			FMT_PNG: begin
				// big-endian: lane = last - idx, last is 3 mod 4
				if (in_rng(cnt_q, PNG_W_FIRST, PNG_W_LAST))
					wid_nxt = wid_q | (32'(data_byte) << {~cnt_q[1:0], 3'b000});
				else if (in_rng(cnt_q, PNG_H_FIRST, PNG_H_LAST))
					hgt_nxt = hgt_q | (32'(data_byte) << {~cnt_q[1:0], 3'b000});
			end
			FMT_JPEG: begin
				if (mark_q) begin
					if (after_q < SOF_CNT_MAX)
						after_nxt = after_q + 4'd1;
					unique case (after_nxt)
						SOF_H_HI: hgt_nxt = hgt_q | {16'd0, data_byte, 8'd0};
						SOF_H_LO: hgt_nxt = hgt_q | {24'd0, data_byte};
						SOF_W_HI: wid_nxt = wid_q | {16'd0, data_byte, 8'd0};
						SOF_W_LO: wid_nxt = wid_q | {24'd0, data_byte};
						default: ;
					endcase
				end else if (cnt_q >= COUNT_BITS'(3) && prev_q == JPEG_MARK &&
						data_byte >= SOF_LO && data_byte <= SOF_HI) begin
					mark_nxt  = 1'b1;
					after_nxt = 4'd1;
				end
			end
			default: ;
		endcase

		cnt_nxt = (cnt_q != '1) ? cnt_q + COUNT_BITS'(1) : cnt_q;
	end

	generate
		if (COUNT_BITS > 32) begin : g_sat
			assign size_sat = (|cnt_nxt[COUNT_BITS-1:32]) ? '1 : cnt_nxt[31:0];
		end else begin : g_ext
			assign size_sat = 32'(cnt_nxt);
		end
	endgenerate

	assign res_push   = take && last_byte;
	assign res.fmt    = fmt_nxt;
	assign res.width  = wid_nxt;
	assign res.height = hgt_nxt;
	assign res.size   = size_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			magic_q <= '0;
			fmt_q   <= FMT_UNKNOWN;
			prev_q  <= '0;
			mark_q  <= 1'b0;
			after_q <= '0;
			wid_q   <= '0;
			hgt_q   <= '0;
		end else if (take) begin
			if (last_byte) begin
				cnt_q   <= '0;
				magic_q <= '0;
				fmt_q   <= FMT_UNKNOWN;
				prev_q  <= '0;
				mark_q  <= 1'b0;
				after_q <= '0;
				wid_q   <= '0;
				hgt_q   <= '0;
			end else begin
				cnt_q   <= cnt_nxt;
				magic_q <= magic_nxt;
				fmt_q   <= fmt_nxt;
				prev_q  <= data_byte;
				mark_q  <= mark_nxt;
				after_q <= after_nxt;
				wid_q   <= wid_nxt;
				hgt_q   <= hgt_nxt;
			end
		end
	end

endmodule

[sv/isn_outbuf.sv]
// ----------------------------------------------------------------------------
// isn_outbuf - result register with skid stage
// Output register plus one spare slot so the input side keeps moving while a
// result waits on the receiver.
// ----------------------------------------------------------------------------
module isn_outbuf import isn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  img_result_t push_data,
	output logic        full,
	output logic        out_valid,
	input  logic        out_ready,
	output img_result_t out_data
);

	logic        out_valid_q;
	img_result_t out_q;
	logic        skid_valid_q;
	img_result_t skid_q;
	logic        pop;

	assign pop       = out_valid_q && out_ready;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
			out_q        <= '0;
			skid_q       <= '0;
		end else if (skid_valid_q) begin
			if (pop) begin
				out_q        <= skid_q;
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_q       <= push_data;
				out_valid_q <= 1'b1;
			end else begin
				skid_q       <= push_data;
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

[sv/isn_checker.sv]
// ----------------------------------------------------------------------------
// isn_checker - port-level checks for the image header size sniffer
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module isn_checker import isn_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [95:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// a stalled result stays up
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// a new result only follows a final byte
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
		else $error("result without a final byte");

	// every file has at least one byte
	a_size: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[95:64] != 32'd0)
		else $error("zero file size");

	// unknown format carries no dimensions
	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == FMT_UNKNOWN |-> m_axis_tdata[63:0] == 64'd0)
		else $error("dimensions on unknown format");

endmodule

bind image_header_size_sniffer isn_checker u_isn_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
